>>> rtl/core/fcp_pkg.sv
// Shared types, sizes and codes for the function call time profiler.
// Used by fcp_stack and function_call_time_profiler; depends on nothing.

package fcp_pkg;

    // Table and stack sizes
    localparam int TABLE_ENTRIES = 64;
    localparam int STACK_DEPTH   = 64;
    localparam int ADDRESS_BITS  = 48;

    // Fixed port widths
    localparam int OP_W       = 2;
    localparam int IN_ADDR_W  = 48;
    localparam int TS_W       = 64;
    localparam int IDX_W      = 6;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 6;
    localparam int LEVEL_W    = 7;

    // Derived internal widths
    localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int FRAME_W = $clog2(STACK_DEPTH);

    // Significant function address bits
    localparam logic [IN_ADDR_W-1:0] ADDR_MASK =
        IN_ADDR_W'({64{1'b1}} >> (64 - ADDRESS_BITS));

    // Operation codes
    localparam logic [OP_W-1:0] OP_ENTER = 2'd0;
    localparam logic [OP_W-1:0] OP_EXIT  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // One table row
    typedef struct packed {
        logic [IN_ADDR_W-1:0] addr;
        logic [TS_W-1:0]      self_acc;
        logic [TS_W-1:0]      child_acc;
        logic [TS_W-1:0]      stamp;
    } t_row;

    // Call stack commands
    typedef struct packed {
        logic              push;
        logic              pop;
        logic              caller_rd;
        logic [SLOT_W-1:0] slot;
    } t_stk_cmd;

    // Call stack status
    typedef struct packed {
        logic [SP_W-1:0]   level;
        logic [SLOT_W-1:0] top;
        logic [SLOT_W-1:0] caller;
    } t_stk_stat;

endpackage

>>> rtl/core/fcp_stack.sv
// Call stack of table slots: frame memory, depth counter and cached top.
// Depends on fcp_pkg.

module fcp_stack import fcp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_stk_cmd  i_cmd,
    output t_stk_stat o_stat
);

    logic [SLOT_W-1:0] r_frame_mem [STACK_DEPTH];
    logic [SP_W-1:0]   r_level;
    logic [SP_W-1:0]   n_level;
    logic [SLOT_W-1:0] r_top;
    logic [SLOT_W-1:0] r_caller;
    logic [SP_W-1:0]   caller_pos;

    // Caller sits one below the top frame
    assign caller_pos = r_level - SP_W'(2);

    // Write pushed frames, read the caller frame
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_frame_mem[r_level[FRAME_W-1:0]] <= i_cmd.slot;
        end
        if (i_cmd.caller_rd) begin
            r_caller <= r_frame_mem[caller_pos[FRAME_W-1:0]];
        end
    end

    // Keep a copy of the top frame; after a pop the caller becomes top
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top <= i_cmd.slot;
        end else if (i_cmd.pop) begin
            r_top <= r_caller;
        end
    end

    // Advance the depth counter
    always_comb begin
        n_level = r_level;
        if (i_cmd.push) begin
            n_level = r_level + SP_W'(1);
        end else if (i_cmd.pop) begin
            n_level = r_level - SP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    assign o_stat.level  = r_level;
    assign o_stat.top    = r_top;
    assign o_stat.caller = r_caller;

endmodule

>>> rtl/core/function_call_time_profiler.sv
// Function call time profiler: per-function self and child tick counts.
// Depends on fcp_pkg and fcp_stack.
//
// Usage: each input word is an enter, exit or read event with a timestamp;
// every event gives exactly one result word. Both channels use valid/ready.
// The table of function rows lives in one synchronous memory (one read,
// one write per cycle, registered read); the call stack lives in a
// second small memory inside fcp_stack. Each row is read, updated and
// written back in order, and a later read of the same row is issued only
// after the write, so no forwarding is needed.
// An enter looks up its address by scanning the table one row per cycle.
// Errors (stack overflow/underflow, empty slot) answer without a table
// access; table full is found after the scan. One event is in work at a
// time; a new event is taken as soon as the previous result has moved
// into the output register.
// Reset clears the stack depth, the allocation count and the output valid;
// the table needs no clearing pass since rows are allocated in order.
// A stalled receiver holds the output word; the block then finishes at
// most one more event and waits with its input ready low.

module function_call_time_profiler import fcp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [IN_ADDR_W-1:0]  i_function_address,
    input  logic [TS_W-1:0]       i_timestamp,
    input  logic [IDX_W-1:0]      i_entry_index,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [SLOT_OUT_W-1:0] o_entry_slot,
    output logic [IN_ADDR_W-1:0]  o_entry_address,
    output logic [TS_W-1:0]       o_self_ticks,
    output logic [TS_W-1:0]       o_total_ticks,
    output logic [LEVEL_W-1:0]    o_stack_level
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_SCAN    = 13'b0000000000010,
        S_CHG_RD  = 13'b0000000000100,
        S_CHG_DLT = 13'b0000000001000,
        S_CHG_WR  = 13'b0000000010000,
        S_ENT_RD  = 13'b0000000100000,
        S_ENT_WR  = 13'b0000001000000,
        S_ALLOC   = 13'b0000010000000,
        S_CLR_RD  = 13'b0000100000000,
        S_CLR_WR  = 13'b0001000000000,
        S_RES_RD  = 13'b0010000000000,
        S_RES     = 13'b0100000000000,
        S_EMIT    = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Latched event
    logic [OP_W-1:0]      r_op;
    logic [IN_ADDR_W-1:0] r_addr;
    logic [TS_W-1:0]      r_ts;

    // Lookup and update bookkeeping
    logic [CNT_W-1:0]  r_used;
    logic [CNT_W-1:0]  r_scan;
    logic              r_cmp_vld;
    logic [SLOT_W-1:0] r_cmp_slot;
    logic              r_found;
    logic [SLOT_W-1:0] r_slot;
    logic [TS_W-1:0]   r_delta;

    // Table memory ports
    t_row              r_tbl_mem [TABLE_ENTRIES];
    t_row              r_tbl_q;
    logic              tbl_re;
    logic [SLOT_W-1:0] tbl_raddr;
    logic              tbl_we;
    logic [SLOT_W-1:0] tbl_waddr;
    t_row              tbl_wdata;

    // Call stack
    t_stk_cmd  stk_cmd;
    t_stk_stat stk_stat;

    // Pending result
    logic [STATUS_W-1:0]   r_res_status;
    logic [SLOT_OUT_W-1:0] r_res_slot;
    logic [IN_ADDR_W-1:0]  r_res_addr;
    logic [TS_W-1:0]       r_res_self;
    logic [TS_W-1:0]       r_res_total;
    logic [LEVEL_W-1:0]    r_res_level;

    // Output register
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    logic [IN_ADDR_W-1:0]  r_out_addr;
    logic [TS_W-1:0]       r_out_self;
    logic [TS_W-1:0]       r_out_total;
    logic [LEVEL_W-1:0]    r_out_level;

    logic in_fire;
    logic out_free;
    logic scan_hit;
    logic scan_miss;
    logic table_full;
    logic stack_full;
    logic stack_empty;
    logic idx_ok;

    fcp_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_stat  (stk_stat)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign scan_hit    = r_cmp_vld && (r_tbl_q.addr == r_addr);
    assign scan_miss   = !r_cmp_vld && (r_scan == r_used);
    assign table_full  = (r_used == CNT_W'(TABLE_ENTRIES));
    assign stack_full  = (stk_stat.level == SP_W'(STACK_DEPTH));
    assign stack_empty = (stk_stat.level == '0);
    // Rows are allocated in order, so a slot is valid below the fill count
    assign idx_ok      = (32'(i_entry_index) < 32'(r_used));

    // Sequence memory accesses and stack commands
    always_comb begin
        n_state   = r_state;
        tbl_re    = 1'b0;
        tbl_raddr = r_slot;
        tbl_we    = 1'b0;
        tbl_waddr = r_slot;
        tbl_wdata = r_tbl_q;
        stk_cmd   = '0;
        stk_cmd.slot = r_slot;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_operation)
                        OP_ENTER: n_state = stack_full  ? S_EMIT : S_SCAN;
                        OP_EXIT:  n_state = stack_empty ? S_EMIT : S_CHG_RD;
                        default:  n_state = idx_ok ? S_RES_RD : S_EMIT;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = stack_empty ? S_ENT_RD : S_CHG_RD;
                end else if (scan_miss) begin
                    if (table_full) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = stack_empty ? S_ALLOC : S_CHG_RD;
                    end
                end else if (r_scan < r_used) begin
                    tbl_re    = 1'b1;
                    tbl_raddr = r_scan[SLOT_W-1:0];
                end
            end
            S_CHG_RD: begin
                tbl_re    = 1'b1;
                tbl_raddr = stk_stat.top;
                stk_cmd.caller_rd = 1'b1;
                n_state   = S_CHG_DLT;
            end
            S_CHG_DLT: begin
                n_state = S_CHG_WR;
            end
            S_CHG_WR: begin
                tbl_we    = 1'b1;
                tbl_waddr = stk_stat.top;
                tbl_wdata.self_acc = r_tbl_q.self_acc + r_delta;
                if (r_op == OP_EXIT) begin
                    stk_cmd.pop = 1'b1;
                    n_state = (stk_stat.level > SP_W'(1)) ? S_CLR_RD : S_RES_RD;
                end else begin
                    n_state = r_found ? S_ENT_RD : S_ALLOC;
                end
            end
            S_ENT_RD: begin
                tbl_re  = 1'b1;
                n_state = S_ENT_WR;
            end
            S_ENT_WR: begin
                tbl_we = 1'b1;
                tbl_wdata.stamp = r_ts;
                stk_cmd.push = 1'b1;
                n_state = S_RES_RD;
            end
            S_ALLOC: begin
                tbl_we = 1'b1;
                tbl_wdata.addr      = r_addr;
                tbl_wdata.self_acc  = '0;
                tbl_wdata.child_acc = '0;
                tbl_wdata.stamp     = r_ts;
                stk_cmd.push = 1'b1;
                n_state = S_RES_RD;
            end
            S_CLR_RD: begin
                tbl_re    = 1'b1;
                tbl_raddr = stk_stat.top;
                n_state   = S_CLR_WR;
            end
            S_CLR_WR: begin
                tbl_we    = 1'b1;
                tbl_waddr = stk_stat.top;
                tbl_wdata.child_acc = r_tbl_q.child_acc + r_delta;
                tbl_wdata.stamp     = r_ts;
                n_state = S_RES_RD;
            end
            S_RES_RD: begin
                tbl_re  = 1'b1;
                n_state = S_RES;
            end
            S_RES: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re) begin
            r_tbl_q <= r_tbl_mem[tbl_raddr];
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_op        <= i_operation;
                    r_addr      <= i_function_address & ADDR_MASK;
                    r_ts        <= i_timestamp;
                    r_scan      <= '0;
                    r_cmp_vld   <= 1'b0;
                    r_res_slot  <= '0;
                    r_res_addr  <= '0;
                    r_res_self  <= '0;
                    r_res_total <= '0;
                    r_res_level <= LEVEL_W'(stk_stat.level);
                    case (i_operation)
                        OP_ENTER: begin
                            r_res_status <= ST_OVERFLOW;
                            r_res_addr   <= i_function_address & ADDR_MASK;
                        end
                        OP_EXIT: begin
                            r_res_status <= ST_UNDERFLOW;
                            r_slot       <= stk_stat.top;
                        end
                        default: begin
                            r_res_status <= ST_EMPTY;
                            r_res_slot   <= i_entry_index;
                            r_slot       <= SLOT_W'(i_entry_index);
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    r_found <= 1'b1;
                    r_slot  <= r_cmp_slot;
                end else if (scan_miss) begin
                    r_found      <= 1'b0;
                    r_slot       <= r_used[SLOT_W-1:0];
                    r_res_status <= ST_FULL;
                    r_res_addr   <= r_addr;
                end else begin
                    r_cmp_vld <= tbl_re;
                    if (tbl_re) begin
                        r_cmp_slot <= r_scan[SLOT_W-1:0];
                        r_scan     <= r_scan + CNT_W'(1);
                    end
                end
            end
            S_CHG_DLT: begin
                r_delta <= r_ts - r_tbl_q.stamp;
            end
            S_RES: begin
                r_res_status <= ST_OK;
                r_res_slot   <= SLOT_OUT_W'(r_slot);
                r_res_addr   <= r_tbl_q.addr;
                r_res_self   <= r_tbl_q.self_acc;
                r_res_total  <= r_tbl_q.self_acc + r_tbl_q.child_acc;
                r_res_level  <= LEVEL_W'(stk_stat.level);
            end
            default: begin
            end
        endcase
    end

    // Load the output word when the result moves out
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && out_free) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_addr   <= r_res_addr;
            r_out_self   <= r_res_self;
            r_out_total  <= r_res_total;
            r_out_level  <= r_res_level;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ALLOC) begin
                r_used <= r_used + CNT_W'(1);
            end
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_entry_slot    = r_out_slot;
    assign o_entry_address = r_out_addr;
    assign o_self_ticks    = r_out_self;
    assign o_total_ticks   = r_out_total;
    assign o_stack_level   = r_out_level;

    // Every accepted word leaves idle at once
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("accepted word did not start processing");

    // A new output word only comes from the emit step
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("output valid raised outside emit");

    // Push never goes beyond the stack depth
    a_push_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_cmd.push |-> (stk_stat.level < SP_W'(STACK_DEPTH)))
        else $error("push on a full call stack");

    // Pop never happens on an empty stack
    a_pop_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_cmd.pop |-> (stk_stat.level != '0))
        else $error("pop on an empty call stack");

    // Allocation never runs past the table
    a_alloc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |-> (r_used < CNT_W'(TABLE_ENTRIES)))
        else $error("allocation on a full table");

endmodule
